>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the plot cell filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PCDF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define PCDF_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PCDF_ASSERT(lbl, clk, rstn, prop, msg)
`define PCDF_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> rtl/pcdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcdf_pkg
// Constants, codes and shared types of the plot cell filter.
// ----------------------------------------------------------------------------
package pcdf_pkg;

  localparam int COLUMNS           = 256;
  localparam int VALUE_ROWS        = 768;
  localparam int PER_COLUMN_BUDGET = 32;
  localparam int LIST_CAPACITY     = 4096;

  localparam int TIME_W   = 40;
  localparam int SPAN_W   = 31;
  localparam int LVL_W    = 11;
  localparam int SRC_W    = 16;
  localparam int IDX_W    = 12;
  localparam int STATUS_W = 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TIME_W;

  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_IDX_W  = $clog2(VALUE_ROWS);
  localparam int CNT_W      = $clog2(PER_COLUMN_BUDGET + 1);
  localparam int TOTAL_W    = $clog2(LIST_CAPACITY + 1);
  localparam int ROW_W      = VALUE_ROWS + CNT_W;
  localparam int DIVIDEND_W = SPAN_W + COL_W;
  localparam int DIV_CNT_W  = $clog2(COL_W + 1);
  localparam int DIFF_W     = TIME_W + 2;
  localparam int LVL_CMP_W  = LVL_W + 1;

  localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(3600);

  typedef enum logic [STATUS_W-1:0] {
    ST_KEPT    = 3'd0,
    ST_OUTSIDE = 3'd1,
    ST_FULL    = 3'd2,
    ST_DUP     = 3'd3,
    ST_CLEARED = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_END  = 2'd0,
    CFG_WINDOW_SPAN = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [SPAN_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [COL_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    status_e           status;
    logic [TIME_W-1:0] out_time;
    logic [LVL_W-1:0]  out_level;
    logic [SRC_W-1:0]  out_source;
    logic              out_kind;
    logic [IDX_W-1:0]  list_index;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/pcdf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcdf_if
// Valid/ready channels for readings in and filter results out.
// ----------------------------------------------------------------------------
interface pcdf_in_if import pcdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [TIME_W-1:0] sample_time;
  logic [LVL_W-1:0]  level;
  logic [SRC_W-1:0]  source_id;
  logic              reading_kind;

  modport source (output valid, func, sample_time, level, source_id, reading_kind,
                  input ready);
  modport sink (input valid, func, sample_time, level, source_id, reading_kind,
                output ready);
endinterface

interface pcdf_out_if import pcdf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TIME_W-1:0]   out_time;
  logic [LVL_W-1:0]    out_level;
  logic [SRC_W-1:0]    out_source;
  logic                out_kind;
  logic [IDX_W-1:0]    list_index;

  modport source (output valid, status, out_time, out_level, out_source, out_kind,
                  list_index, input ready);
  modport sink (input valid, status, out_time, out_level, out_source, out_kind,
                list_index, output ready);
endinterface
`default_nettype wire

>>> rtl/pcdf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcdf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module pcdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> rtl/pcdf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcdf_div
// Restoring divider producing one column quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcdf_div import pcdf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SPAN_W-1:0]    rem_q;
  logic [SPAN_W-1:0]    dvs_q;
  logic [COL_W-1:0]     low_q;
  logic [COL_W-1:0]     quo_q;
  logic [SPAN_W:0]      trial;
  logic [SPAN_W:0]      diff;
  logic                 ge;

  assign trial = {rem_q, low_q[COL_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(COL_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= SPAN_W'(req_i.dividend >> COL_W);
      low_q <= req_i.dividend[COL_W-1:0];
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? SPAN_W'(diff) : SPAN_W'(trial);
      low_q <= COL_W'({low_q, 1'b0});
      quo_q <= COL_W'({quo_q, ge});
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire

>>> rtl/plot_cell_dedupe_filter_core.sv
// A reading in the window goes from transfer through S_MUL, S_DIV and S_CHK
// to S_DONE, waiting in S_DIV on the bit-serial column divider (one quotient
// bit per cycle). Clear items and readings outside the window or value range
// go straight to S_DONE. One item is in work at a time; the next transfer is
// taken once its result is registered. Reset empties the cell bitmap and column
// counts through per-column valid flags, so no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// plot_cell_dedupe_filter_core
// Maps readings onto a plot raster and keeps one point per marked cell.
// ----------------------------------------------------------------------------
module plot_cell_dedupe_filter_core import pcdf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pcdf_in_if.sink               in_ch,
  pcdf_out_if.source            out_ch
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_CHK  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [TIME_W-1:0]   end_q;
  logic [SPAN_W-1:0]   span_q;
  logic [TIME_W-1:0]   time_q;
  logic [LVL_W-1:0]    lvl_q;
  logic [SRC_W-1:0]    src_q;
  logic                kind_q;
  logic [SPAN_W-1:0]   delta_q;
  logic [COL_W-1:0]    col_q;
  logic [COLUMNS-1:0]  row_valid_q;
  logic [TOTAL_W-1:0]  kept_total_q;
  result_t             res_q;
  result_t             res_d;
  result_t             out_q;
  logic                out_valid_q;

  logic                in_xfer;
  logic [DIFF_W-1:0]   diff;
  logic                in_window;
  logic                lvl_ok;
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [ROW_W-1:0]    rd_data;
  logic [ROW_W-1:0]    row;
  logic [CNT_W-1:0]    count;
  logic [VALUE_ROWS-1:0] marks;
  logic [VALUE_ROWS-1:0] new_marks;
  logic                mark_hit;
  logic                full;
  logic                ram_we;
  logic [ROW_W-1:0]    wdata;
  logic                slot_free;

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_xfer     = in_ch.valid & in_ch.ready;

  assign diff = DIFF_W'(in_ch.sample_time) + DIFF_W'(span_q) - DIFF_W'(end_q);
  assign in_window = (in_ch.sample_time <= end_q) && !diff[DIFF_W-1] && (diff != '0);
  assign lvl_ok = LVL_CMP_W'(in_ch.level) < LVL_CMP_W'(VALUE_ROWS);

  assign div_req.start    = (state_q == S_MUL);
  assign div_req.dividend = DIVIDEND_W'(delta_q) * DIVIDEND_W'(COLUMNS - 1);
  assign div_req.divisor  = span_q;

  pcdf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pcdf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (COLUMNS)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i (wdata),
    .re_i    (div_rsp.done),
    .raddr_i (div_rsp.quotient),
    .rdata_o (rd_data)
  );

  assign row       = row_valid_q[col_q] ? rd_data : '0;
  assign count     = row[ROW_W-1 -: CNT_W];
  assign marks     = row[VALUE_ROWS-1:0];
  assign mark_hit  = marks[lvl_q[ROW_IDX_W-1:0]];
  assign new_marks = marks | (VALUE_ROWS'(1) << lvl_q[ROW_IDX_W-1:0]);
  assign full      = (count >= CNT_W'(PER_COLUMN_BUDGET)) ||
                     (kept_total_q >= TOTAL_W'(LIST_CAPACITY));
  assign ram_we    = (state_q == S_CHK) && !full && !mark_hit;
  assign wdata     = {count + 1'b1, new_marks};
  assign slot_free = !out_valid_q || out_ch.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = (in_ch.func && in_window && lvl_ok) ? S_MUL : S_DONE;
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_CHK;
        end
      end
      S_CHK: state_d = S_DONE;
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_d = res_q;
    if (in_xfer) begin
      res_d        = '0;
      res_d.status = in_ch.func ? ST_OUTSIDE : ST_CLEARED;
    end else if (state_q == S_CHK) begin
      res_d = '0;
      if (full) begin
        res_d.status = ST_FULL;
      end else if (mark_hit) begin
        res_d.status = ST_DUP;
      end else begin
        res_d.status     = ST_KEPT;
        res_d.out_time   = time_q;
        res_d.out_level  = lvl_q;
        res_d.out_source = src_q;
        res_d.out_kind   = kind_q;
        res_d.list_index = IDX_W'(kept_total_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      end_q        <= '0;
      span_q       <= SPAN_RESET;
      row_valid_q  <= '0;
      kept_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WINDOW_END:  end_q  <= cfg_data_i[TIME_W-1:0];
          CFG_WINDOW_SPAN: span_q <= cfg_data_i[SPAN_W-1:0];
          default: ;
        endcase
      end
      if (in_xfer && !in_ch.func) begin
        row_valid_q  <= '0;
        kept_total_q <= '0;
      end
      if (ram_we) begin
        row_valid_q[col_q] <= 1'b1;
        kept_total_q       <= kept_total_q + 1'b1;
      end
      if (state_q == S_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      time_q  <= in_ch.sample_time;
      lvl_q   <= in_ch.level;
      src_q   <= in_ch.source_id;
      kind_q  <= in_ch.reading_kind;
      delta_q <= SPAN_W'(diff);
    end
    if (div_rsp.done) begin
      col_q <= div_rsp.quotient;
    end
    res_q <= res_d;
    if (state_q == S_DONE && slot_free) begin
      out_q <= res_q;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.status     = out_q.status;
  assign out_ch.out_time   = out_q.out_time;
  assign out_ch.out_level  = out_q.out_level;
  assign out_ch.out_source = out_q.out_source;
  assign out_ch.out_kind   = out_q.out_kind;
  assign out_ch.list_index = out_q.list_index;

  `PCDF_ASSERT_NEVER(a_total_bound, clk_i, rst_ni, kept_total_q > TOTAL_W'(LIST_CAPACITY), "kept total exceeds list capacity")
  `PCDF_ASSERT(a_keep_counts, clk_i, rst_ni, ram_we |=> kept_total_q == TOTAL_W'($past(kept_total_q) + 1'b1), "kept row write without total increment")
  `PCDF_ASSERT(a_div_done_state, clk_i, rst_ni, div_rsp.done |-> state_q == S_DIV, "divider finished outside the divide state")

endmodule
`default_nettype wire
